// File: rtl/lck_pkg.sv
package lck_pkg;

  localparam int ADC_W     = 12;
  localparam int ELAPSED_W = 16;
  localparam int KEY_W     = 3;
  localparam int TOTAL_W   = 31;
  localparam int LADDER_KEYS = 4;
  localparam int REG_IDX_W = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // reset values of the configuration registers
  localparam logic [ADC_W-1:0] LEVEL_ONE_RST   = 12'd650;
  localparam logic [ADC_W-1:0] LEVEL_TWO_RST   = 12'd1880;
  localparam logic [ADC_W-1:0] LEVEL_THREE_RST = 12'd2520;
  localparam logic [ADC_W-1:0] LEVEL_FOUR_RST  = 12'd1230;
  localparam logic [ADC_W-1:0] TOLERANCE_RST   = 12'd20;

  localparam logic [ADC_W-1:0] PREV_SAMPLE_RST = 12'd1;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEVEL_ONE   = 3'd0,
    REG_LEVEL_TWO   = 3'd1,
    REG_LEVEL_THREE = 3'd2,
    REG_LEVEL_FOUR  = 3'd3,
    REG_TOLERANCE   = 3'd4
  } lck_reg_t;

  typedef struct packed {
    logic [LADDER_KEYS-1:0][ADC_W-1:0] levels;
    logic [ADC_W-1:0]                  tolerance;
  } lck_cfg_t;

  function automatic logic [ADC_W-1:0] abs_diff(input logic [ADC_W-1:0] a,
                                                input logic [ADC_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: rtl/lck_if.sv
interface lck_in_if import lck_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [KEY_W-1:0]     touch_key;
  logic                 adc_enable;
  logic [ADC_W-1:0]     adc_sample;

  modport source (output valid, elapsed_ms, touch_key, adc_enable, adc_sample,
                  input ready);
  modport sink   (input valid, elapsed_ms, touch_key, adc_enable, adc_sample,
                  output ready);
endinterface

interface lck_out_if import lck_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   active_channel;
  logic [KEY_W-1:0]   ladder_hit;
  logic [TOTAL_W-1:0] total_one;
  logic [TOTAL_W-1:0] total_two;
  logic [TOTAL_W-1:0] total_three;
  logic [TOTAL_W-1:0] total_four;

  modport source (output valid, active_channel, ladder_hit, total_one, total_two,
                  total_three, total_four, input ready);
  modport sink   (input valid, active_channel, ladder_hit, total_one, total_two,
                  total_three, total_four, output ready);
endinterface

interface lck_cfg_if import lck_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [ADC_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/lck_cfg.sv
module lck_cfg import lck_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  lck_cfg_if.sink  cfg_ch,
  output lck_cfg_t cfg
);

  lck_cfg_t cfg_r;

  // always ready, writes are registered
  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.levels[0] <= LEVEL_ONE_RST;
      cfg_r.levels[1] <= LEVEL_TWO_RST;
      cfg_r.levels[2] <= LEVEL_THREE_RST;
      cfg_r.levels[3] <= LEVEL_FOUR_RST;
      cfg_r.tolerance <= TOLERANCE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LEVEL_ONE:   cfg_r.levels[0] <= cfg_ch.data;
        REG_LEVEL_TWO:   cfg_r.levels[1] <= cfg_ch.data;
        REG_LEVEL_THREE: cfg_r.levels[2] <= cfg_ch.data;
        REG_LEVEL_FOUR:  cfg_r.levels[3] <= cfg_ch.data;
        REG_TOLERANCE:   cfg_r.tolerance <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/lck_pass.sv
module lck_pass import lck_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int CH_W     = 3
) (
  input  lck_cfg_t             cfg,
  input  logic [ELAPSED_W-1:0] elapsed_ms,
  input  logic [KEY_W-1:0]     touch_key,
  input  logic                 adc_enable,
  input  logic [ADC_W-1:0]     adc_sample,
  input  logic [CH_W-1:0]      running,
  input  logic [ADC_W-1:0]     prev_sample,
  input  logic [TOTAL_W-1:0]   totals [CHANNELS],
  output logic [CH_W-1:0]      running_nxt,
  output logic [ADC_W-1:0]     prev_sample_nxt,
  output logic [TOTAL_W-1:0]   totals_nxt [CHANNELS],
  output logic [KEY_W-1:0]     ladder_hit
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NKEYS = (CHANNELS < LADDER_KEYS) ? CHANNELS : LADDER_KEYS;

  logic [IDX_W-1:0]   run_idx;
  logic               run_ok;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] new_total;
  logic [CH_W-1:0]    after_touch;
  logic [NKEYS-1:0]   match;
  logic               moved;
  logic               found;
  logic [KEY_W-1:0]   hit;

  // saturating add on the running channel
  assign run_ok  = (running != '0) && (int'(running) <= CHANNELS);
  assign run_idx = IDX_W'(running - CH_W'(1));
  assign sum     = {1'b0, totals[run_idx]} + (TOTAL_W + 1)'(elapsed_ms);
  assign new_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      totals_nxt[i] = (run_ok && (run_idx == IDX_W'(i))) ? new_total : totals[i];
    end
  end

  // touch key toggles its channel
  always_comb begin
    after_touch = running;
    if ((touch_key != '0) && (int'(touch_key) <= CHANNELS)) begin
      after_touch = (running == CH_W'(touch_key)) ? '0 : CH_W'(touch_key);
    end
  end

  // ladder level windows, first match wins
  assign moved = abs_diff(adc_sample, prev_sample) > cfg.tolerance;

  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      match[k] = abs_diff(adc_sample, cfg.levels[k]) < cfg.tolerance;
    end
  end

  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int k = NKEYS - 1; k >= 0; k--) begin
      if (match[k]) begin
        found = 1'b1;
        hit   = KEY_W'(k + 1);
      end
    end
  end

  always_comb begin
    running_nxt     = after_touch;
    prev_sample_nxt = prev_sample;
    ladder_hit      = '0;
    if (adc_enable) begin
      if (adc_sample == '0) begin
        prev_sample_nxt = '0;
      end else if (found && moved) begin
        ladder_hit      = hit;
        prev_sample_nxt = adc_sample;
        running_nxt     = (after_touch == CH_W'(hit)) ? '0 : CH_W'(hit);
      end
    end
  end

endmodule

// File: rtl/ladder_key_exclusive_stopwatch_top.sv
// an accepted word goes from the input stage through the result register to the output
// throughput: one word per cycle unless out_ch.ready stalls, set by the input stage and result register
// all stopwatch state lives in the single pass stage, so back-to-back words see each update
// reset (synchronous, active low): stopwatches stopped, totals zero,
// previous sample one, level and tolerance registers at their defaults
module ladder_key_exclusive_stopwatch_top import lck_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  lck_cfg_if.sink cfg_ch,
  lck_in_if.sink  in_ch,
  lck_out_if.source out_ch
);

  localparam int CH_W = $clog2(CHANNELS + 1);
  localparam int OUT_N = (CHANNELS < 4) ? CHANNELS : 4;

  lck_cfg_t cfg;

  // input stage
  logic                 s1_valid_r;
  logic [ELAPSED_W-1:0] s1_elapsed_r;
  logic [KEY_W-1:0]     s1_key_r;
  logic                 s1_enable_r;
  logic [ADC_W-1:0]     s1_sample_r;

  // state
  logic [CH_W-1:0]    running_r;
  logic [CH_W-1:0]    running_nxt;
  logic [ADC_W-1:0]   prev_sample_r;
  logic [ADC_W-1:0]   prev_sample_nxt;
  logic [TOTAL_W-1:0] totals_r   [CHANNELS];
  logic [TOTAL_W-1:0] totals_nxt [CHANNELS];
  logic [KEY_W-1:0]   hit;

  // result register
  logic               out_valid_r;
  logic [KEY_W-1:0]   out_active_r;
  logic [KEY_W-1:0]   out_hit_r;
  logic [TOTAL_W-1:0] out_totals_r [4];

  logic s1_fire;
  logic in_fire;
  logic [7:0] run_wide;

  lck_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // handshake
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_elapsed_r <= in_ch.elapsed_ms;
      s1_key_r     <= in_ch.touch_key;
      s1_enable_r  <= in_ch.adc_enable;
      s1_sample_r  <= in_ch.adc_sample;
    end
  end

  lck_pass #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_pass (
    .cfg             (cfg),
    .elapsed_ms      (s1_elapsed_r),
    .touch_key       (s1_key_r),
    .adc_enable      (s1_enable_r),
    .adc_sample      (s1_sample_r),
    .running         (running_r),
    .prev_sample     (prev_sample_r),
    .totals          (totals_r),
    .running_nxt     (running_nxt),
    .prev_sample_nxt (prev_sample_nxt),
    .totals_nxt      (totals_nxt),
    .ladder_hit      (hit)
  );

  // state update once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r     <= '0;
      prev_sample_r <= PREV_SAMPLE_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        totals_r[i] <= '0;
      end
    end else if (s1_fire) begin
      running_r     <= running_nxt;
      prev_sample_r <= prev_sample_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        totals_r[i] <= totals_nxt[i];
      end
    end
  end

  // result register
  assign run_wide = 8'(running_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_active_r <= run_wide[KEY_W-1:0];
      out_hit_r    <= hit;
      for (int i = 0; i < 4; i++) begin
        out_totals_r[i] <= (i < OUT_N) ? totals_nxt[i % CHANNELS] : '0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.active_channel = out_active_r;
  assign out_ch.ladder_hit     = out_hit_r;
  assign out_ch.total_one      = out_totals_r[0];
  assign out_ch.total_two      = out_totals_r[1];
  assign out_ch.total_three    = out_totals_r[2];
  assign out_ch.total_four     = out_totals_r[3];

endmodule

// File: sim/ladder_key_exclusive_stopwatch_top_tb.sv
module ladder_key_exclusive_stopwatch_top_tb;
  import lck_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS      = 4;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int SOAK_PASSES   = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic [KEY_W-1:0]     touch_key;
    logic                 adc_enable;
    logic [ADC_W-1:0]     adc_sample;
  } pass_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]              active;
    logic [KEY_W-1:0]              hit;
    logic [3:0][TOTAL_W-1:0]       totals;
  } readout_t;

  typedef enum logic [2:0] {
    STEP_PASS,
    STEP_REG,
    STEP_SETTLE,
    STEP_HOLDOFF,
    STEP_PACE
  } step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    pass_word_t       word;
    lck_reg_t         reg_idx;
    logic [ADC_W-1:0] value;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lck_cfg_if cfg_if ();
  lck_in_if  in_if ();
  lck_out_if out_if ();

  ladder_key_exclusive_stopwatch_top #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_if),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always #1 clk = ~clk;

  // stimulus plan and expected readouts
  step_t      plan_steps[$];
  readout_t   pending_readouts[$];

  // predictor state and register copy
  logic [ADC_W-1:0]   lvl_copy[LADDER_KEYS];
  logic [ADC_W-1:0]   tol_copy;
  logic [KEY_W-1:0]   run_ch;
  logic [ADC_W-1:0]   last_sample;
  logic [TOTAL_W-1:0] ch_totals[CHANNELS];

  // register values the plan is aiming its samples at
  int plan_lvl[LADDER_KEYS];
  int plan_tol;

  int errors = 0;
  int words_checked = 0;
  int reg_writes = 0;
  int hits_seen = 0;
  int saturated_seen = 0;
  int cycle_count = 0;

  // driver and monitor bookkeeping
  pass_word_t cur_word;
  lck_reg_t   cur_reg;
  logic [ADC_W-1:0] cur_value;
  int   gap_left = 0;
  int   settle_cnt = 0;
  logic pace_on = 1'b1;
  logic sink_pace = 1'b1;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;
  int   stall_left = 0;
  logic stim_done = 1'b0;

  function automatic logic [ADC_W-1:0] spread(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void flip_channel(logic [KEY_W-1:0] ch);
    run_ch = (run_ch == ch) ? '0 : ch;
  endfunction

  // one polling pass: accumulate, touch toggle, then ladder evaluation
  function automatic readout_t stopwatch_pass(pass_word_t w);
    readout_t         r;
    logic [KEY_W-1:0] hit;
    logic [TOTAL_W:0] sum;
    hit = '0;
    if (run_ch >= 1 && run_ch <= CHANNELS) begin
      sum = {1'b0, ch_totals[run_ch-1]} + w.elapsed;
      ch_totals[run_ch-1] = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end
    if (w.touch_key >= 1 && w.touch_key <= CHANNELS)
      flip_channel(w.touch_key);
    if (w.adc_enable) begin
      if (w.adc_sample == '0) begin
        last_sample = '0;
      end else begin
        for (int k = 0; k < LADDER_KEYS && k < CHANNELS; k++) begin
          if (hit == '0 && spread(w.adc_sample, lvl_copy[k]) < tol_copy &&
              spread(w.adc_sample, last_sample) > tol_copy) begin
            hit = KEY_W'(k + 1);
            flip_channel(hit);
            last_sample = w.adc_sample;
          end
        end
      end
    end
    r.active = run_ch;
    r.hit    = hit;
    for (int k = 0; k < 4; k++)
      r.totals[k] = (k < CHANNELS) ? ch_totals[k] : '0;
    return r;
  endfunction

  function automatic void load_register(lck_reg_t idx, logic [ADC_W-1:0] value);
    case (idx)
      REG_LEVEL_ONE:   lvl_copy[0] = value;
      REG_LEVEL_TWO:   lvl_copy[1] = value;
      REG_LEVEL_THREE: lvl_copy[2] = value;
      REG_LEVEL_FOUR:  lvl_copy[3] = value;
      REG_TOLERANCE:   tol_copy = value;
      default: ;
    endcase
  endfunction

  task automatic flag(string what, longint got, longint want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("mismatch at word %0d, %s: got %0d, expected %0d",
               words_checked, what, got, want);
  endtask

  // plan building helpers
  task automatic add_pass(int elapsed, int key, int en, int sample);
    step_t s;
    s = '0;
    s.kind = STEP_PASS;
    s.word.elapsed    = ELAPSED_W'(elapsed);
    s.word.touch_key  = KEY_W'(key);
    s.word.adc_enable = en[0];
    s.word.adc_sample = ADC_W'(sample);
    plan_steps.push_back(s);
  endtask

  task automatic add_marker(step_kind_t kind, int value);
    step_t s;
    s = '0;
    s.kind  = kind;
    s.value = ADC_W'(value);
    plan_steps.push_back(s);
  endtask

  // settle the block, then write every register
  task automatic queue_settings(int l1, int l2, int l3, int l4, int tol);
    step_t s;
    add_marker(STEP_SETTLE, 0);
    plan_lvl[0] = l1;
    plan_lvl[1] = l2;
    plan_lvl[2] = l3;
    plan_lvl[3] = l4;
    plan_tol = tol;
    s = '0;
    s.kind = STEP_REG;
    s.reg_idx = REG_LEVEL_ONE;   s.value = ADC_W'(l1);  plan_steps.push_back(s);
    s.reg_idx = REG_LEVEL_TWO;   s.value = ADC_W'(l2);  plan_steps.push_back(s);
    s.reg_idx = REG_LEVEL_THREE; s.value = ADC_W'(l3);  plan_steps.push_back(s);
    s.reg_idx = REG_LEVEL_FOUR;  s.value = ADC_W'(l4);  plan_steps.push_back(s);
    s.reg_idx = REG_TOLERANCE;   s.value = ADC_W'(tol); plan_steps.push_back(s);
  endtask

  function automatic int rand_elapsed();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                       : int'($urandom_range(0, 2000));
  endfunction

  function automatic int rand_touch();
    return ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 7)) : 0;
  endfunction

  // mostly key presses near a level followed by a release, some noise
  task automatic queue_ladder_phase(int count);
    int n;
    int k;
    int reps;
    int v;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, LADDER_KEYS - 1);
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          v = plan_lvl[k] + int'($urandom_range(0, 2 * plan_tol + 2)) - plan_tol - 1;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          add_pass(rand_elapsed(), rand_touch(), ($urandom_range(0, 9) != 0), v);
          n++;
        end
        if ($urandom_range(0, 3) != 0) begin
          add_pass(rand_elapsed(), rand_touch(), 1, 0);
          n++;
        end
      end else begin
        add_pass($urandom_range(0, 65535), $urandom_range(0, 7), $urandom_range(0, 1),
                 $urandom_range(0, 4095));
        n++;
      end
    end
  endtask

  // driver: offers words and register writes, predicts on acceptance
  always @(posedge clk) begin : feed
    logic  nxt_in_valid;
    logic  nxt_cfg_valid;
    logic  nxt_hold;
    step_t st;
    pass_word_t got;
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      cfg_if.valid <= 1'b0;
      hold_req     <= 1'b0;
    end else begin
      nxt_in_valid  = in_if.valid;
      nxt_cfg_valid = cfg_if.valid;
      nxt_hold      = 1'b0;
      if (in_if.valid && in_if.ready) begin
        got.elapsed    = in_if.elapsed_ms;
        got.touch_key  = in_if.touch_key;
        got.adc_enable = in_if.adc_enable;
        got.adc_sample = in_if.adc_sample;
        pending_readouts.push_back(stopwatch_pass(got));
        nxt_in_valid = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        load_register(lck_reg_t'(cfg_if.index), cfg_if.data);
        reg_writes++;
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (plan_steps.size() != 0) begin
          st = plan_steps[0];
          case (st.kind)
            STEP_PASS: begin
              cur_word = st.word;
              nxt_in_valid = 1'b1;
              void'(plan_steps.pop_front());
              if (pace_on && $urandom_range(0, 4) == 0)
                gap_left = $urandom_range(1, 10);
            end
            STEP_REG: begin
              cur_reg = st.reg_idx;
              cur_value = st.value;
              nxt_cfg_valid = 1'b1;
              void'(plan_steps.pop_front());
            end
            STEP_SETTLE: begin
              // wait for every result, then let the block settle
              if (pending_readouts.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
              end else begin
                settle_cnt = 0;
                void'(plan_steps.pop_front());
              end
            end
            STEP_HOLDOFF: begin
              nxt_hold = 1'b1;
              void'(plan_steps.pop_front());
            end
            STEP_PACE: begin
              pace_on = st.value[0];
              void'(plan_steps.pop_front());
            end
            default: void'(plan_steps.pop_front());
          endcase
        end else begin
          stim_done = 1'b1;
        end
      end
      in_if.valid      <= nxt_in_valid;
      in_if.elapsed_ms <= cur_word.elapsed;
      in_if.touch_key  <= cur_word.touch_key;
      in_if.adc_enable <= cur_word.adc_enable;
      in_if.adc_sample <= cur_word.adc_sample;
      cfg_if.valid     <= nxt_cfg_valid;
      cfg_if.index     <= cur_reg;
      cfg_if.data      <= cur_value;
      hold_req         <= nxt_hold;
    end
    sink_pace <= pace_on;
  end

  // long output hold-off, counted on its own
  always @(posedge clk) begin
    if (!rst_n)
      hold_cnt <= 0;
    else if (hold_req)
      hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0)
      hold_cnt <= hold_cnt - 1;
  end

  // monitor: checks each result word against the oldest prediction
  always @(posedge clk) begin : watch
    logic     nxt_ready;
    readout_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_readouts.size() == 0) begin
          flag("word with nothing expected", out_if.active_channel, 0);
        end else begin
          want = pending_readouts.pop_front();
          if (out_if.active_channel !== want.active)
            flag("active_channel", out_if.active_channel, want.active);
          if (out_if.ladder_hit !== want.hit)
            flag("ladder_hit", out_if.ladder_hit, want.hit);
          if (out_if.total_one !== want.totals[0])
            flag("total_one", out_if.total_one, want.totals[0]);
          if (out_if.total_two !== want.totals[1])
            flag("total_two", out_if.total_two, want.totals[1]);
          if (out_if.total_three !== want.totals[2])
            flag("total_three", out_if.total_three, want.totals[2]);
          if (out_if.total_four !== want.totals[3])
            flag("total_four", out_if.total_four, want.totals[3]);
          if (want.hit != '0)
            hits_seen++;
          if (want.totals[3] == TOTAL_MAX)
            saturated_seen++;
        end
        words_checked++;
      end
      if (hold_cnt != 0) begin
        nxt_ready = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (sink_pace && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_if.ready <= nxt_ready;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_readouts.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.elapsed_ms = '0;
    in_if.touch_key  = '0;
    in_if.adc_enable = 1'b0;
    in_if.adc_sample = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_LEVEL_ONE;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    cur_word  = '0;
    cur_reg   = REG_LEVEL_ONE;
    cur_value = '0;

    // state after reset
    lvl_copy[0] = LEVEL_ONE_RST;
    lvl_copy[1] = LEVEL_TWO_RST;
    lvl_copy[2] = LEVEL_THREE_RST;
    lvl_copy[3] = LEVEL_FOUR_RST;
    tol_copy    = TOLERANCE_RST;
    run_ch      = '0;
    last_sample = PREV_SAMPLE_RST;
    for (int k = 0; k < CHANNELS; k++)
      ch_totals[k] = '0;
    plan_lvl[0] = int'(LEVEL_ONE_RST);
    plan_lvl[1] = int'(LEVEL_TWO_RST);
    plan_lvl[2] = int'(LEVEL_THREE_RST);
    plan_lvl[3] = int'(LEVEL_FOUR_RST);
    plan_tol    = int'(TOLERANCE_RST);

    // directed: touch keys, ignored keys, disabled converter
    add_pass(0, 0, 0, 0);
    add_pass(65535, 1, 0, 0);
    add_pass(65535, 0, 0, 4095);
    add_pass(1234, 2, 0, 0);
    add_pass(100, 5, 0, 0);
    add_pass(100, 6, 0, 0);
    add_pass(100, 7, 0, 0);
    add_pass(50, 2, 0, 0);
    // ladder hits, repeat sample, zero release, window edges
    add_pass(10, 0, 1, 650);
    add_pass(10, 0, 1, 650);
    add_pass(10, 0, 1, 0);
    add_pass(10, 0, 1, 1880 + 19);
    add_pass(10, 0, 1, 0);
    add_pass(10, 0, 1, 2520 + 20);
    // touch and ladder on the same channel cancel out
    add_pass(10, 3, 1, 2520 - 19);
    add_pass(10, 0, 1, 0);
    add_pass(10, 0, 1, 1230);
    add_pass(10, 0, 1, 0);
    // change from previous sample must exceed the tolerance
    add_pass(10, 0, 1, 631);
    add_pass(10, 0, 1, 651);
    add_pass(10, 0, 1, 652);
    add_pass(10, 1, 1, 4095);
    add_pass(65535, 1, 0, 0);

    // short run on channel four, back to back
    add_marker(STEP_PACE, 0);
    add_pass(65535, 4, 0, 0);
    repeat (SOAK_PASSES) add_pass(65535, 0, 0, 0);
    add_pass(65535, 4, 0, 0);
    add_marker(STEP_PACE, 1);

    // random phases over several register settings
    queue_ladder_phase(160);
    queue_settings(0, 0, 0, 0, 0);
    queue_ladder_phase(80);
    queue_settings(4095, 4095, 4095, 4095, 4095);
    queue_ladder_phase(80);
    queue_settings(1000, 1010, 1020, 1030, 25);
    queue_ladder_phase(130);
    queue_settings($urandom_range(1, 4095), $urandom_range(1, 4095),
                   $urandom_range(1, 4095), $urandom_range(1, 4095),
                   $urandom_range(1, 200));
    queue_ladder_phase(80);
    // hold the output while words keep coming
    add_marker(STEP_PACE, 0);
    add_marker(STEP_HOLDOFF, 0);
    queue_ladder_phase(50);
    add_marker(STEP_PACE, 1);
    queue_ladder_phase(60);
    queue_settings(int'(LEVEL_ONE_RST), int'(LEVEL_TWO_RST), int'(LEVEL_THREE_RST),
                   int'(LEVEL_FOUR_RST), 1);
    queue_ladder_phase(60);
    // closing stretch without idling
    queue_settings(int'(LEVEL_ONE_RST), int'(LEVEL_TWO_RST), int'(LEVEL_THREE_RST),
                   int'(LEVEL_FOUR_RST), int'(TOLERANCE_RST));
    add_marker(STEP_PACE, 0);
    queue_ladder_phase(120);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (!stim_done) @(posedge clk);
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d result words, %0d register writes, %0d ladder hits",
             words_checked, reg_writes, hits_seen);
    $display("register settings from zero to full scale, %0d words with a saturated total",
             saturated_seen);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
